// File: rtl/core/bgauge_pkg.sv
// Shared types and constants for the battery gauge core.
// No dependencies; imported by every module of the block.
`default_nettype none

package bgauge_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned VoltWidth  = 13;
   localparam int unsigned CodeWidth  = 8;
   localparam int unsigned PctWidth   = 7;
   localparam int unsigned StepCount  = 9;

   // reply character checks
   localparam logic [CharWidth-1:0] CHAR_MIN_HUNDREDS = 8'h33;
   localparam logic [CharWidth-1:0] CHAR_DIGIT_LO     = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_DIGIT_HI     = 8'h39;

   // ASCII bias (5328) plus code offset (330), taken mod 256
   localparam logic [CodeWidth-1:0] CODE_BIAS        = 8'd26;
   localparam logic [CodeWidth-1:0] CODE_MIN         = 8'd113;

   localparam logic [VoltWidth-1:0] VOLT_RESET       = 13'd3699;
   localparam logic [VoltWidth-1:0] MV_BASE          = 13'd2440;
   localparam logic [9:0]           LEVEL_BASE       = 10'd305;

   localparam logic [CodeWidth-1:0] LVL_NORMAL_ABOVE = 8'd145;
   localparam logic [CodeWidth-1:0] LVL_ULTRA_BELOW  = 8'd122;
   localparam logic [CodeWidth-1:0] LVL_LOW_BELOW    = 8'd138;
   localparam logic [CodeWidth-1:0] LVL_FULL         = 8'd212;

   localparam logic [PctWidth-1:0]  PCT_RESET        = 7'd12;
   localparam logic [PctWidth-1:0]  PCT_DEFAULT      = 7'd44;
   localparam logic [PctWidth-1:0]  PCT_LOW          = 7'd5;
   localparam logic [PctWidth-1:0]  PCT_ULTRA        = 7'd1;
   localparam logic [PctWidth-1:0]  PCT_FULL         = 7'd100;

   typedef logic [CodeWidth-1:0] step_thresh_type [StepCount];
   typedef logic [PctWidth-1:0]  step_pct_type    [StepCount];

   localparam step_thresh_type STEP_THRESH = '{
      8'd203, 8'd191, 8'd182, 8'd170, 8'd163, 8'd157, 8'd151, 8'd145, 8'd138
   };
   localparam step_pct_type STEP_PCT = '{
      7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10
   };

   typedef enum logic [1:0] {
      LOW_NORMAL = 2'd0,
      LOW_LOW    = 2'd1,
      LOW_ULTRA  = 2'd2
   } low_state_type;

   // decoded reply handed from the decoder to the state update
   typedef struct packed {
      logic                 taken;
      logic [CodeWidth-1:0] code;
   } sample_type;

   // state after one reply, as reported on the result channel
   typedef struct packed {
      logic                 taken;
      logic [VoltWidth-1:0] voltage;
      low_state_type        low;
      logic [PctWidth-1:0]  percent;
   } gauge_type;

endpackage

`default_nettype wire

// File: rtl/core/bgauge_decode.sv
// ASCII reply checker and 8-bit code former.
// Depends on bgauge_pkg.
`default_nettype none

module bgauge_decode (
   input  wire logic [7:0]             digit_hundreds,
   input  wire logic [7:0]             digit_tens,
   input  wire logic [7:0]             digit_units,
   output bgauge_pkg::sample_type      sample
);
   import bgauge_pkg::*;

   logic                 reply_ok;
   logic [CodeWidth-1:0] part_hundreds;
   logic [CodeWidth-1:0] part_tens;
   logic [CodeWidth-1:0] code;

   assign reply_ok = (digit_hundreds >= CHAR_MIN_HUNDREDS) &&
                     (digit_units >= CHAR_DIGIT_LO) && (digit_units <= CHAR_DIGIT_HI);

   // only the low byte of the decimal value survives
   assign part_hundreds = 8'(16'(digit_hundreds) * 16'd100);
   assign part_tens     = 8'(16'(digit_tens) * 16'd10);
   assign code          = part_hundreds + part_tens + digit_units - CODE_BIAS;

   assign sample.taken = reply_ok && (code > CODE_MIN);
   assign sample.code  = code;

endmodule

`default_nettype wire

// File: rtl/core/bgauge_state.sv
// Gauge state: filtered voltage, level code, low state with hysteresis, percentage.
// Depends on bgauge_pkg.
`default_nettype none

module bgauge_state (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  update,
   input  wire bgauge_pkg::sample_type sample,
   input  wire logic                  level_update,
   output bgauge_pkg::gauge_type      gauge_next
);
   import bgauge_pkg::*;

   logic [VoltWidth-1:0] volt_ff,    volt_in;
   logic                 have_ff,    have_in;
   logic [CodeWidth-1:0] level_ff,   level_in;
   low_state_type        low_ff,     low_in;
   logic [PctWidth-1:0]  pct_ff,     pct_in;

   logic [VoltWidth-1:0] volt_get;
   logic [VoltWidth-1:0] volt_prev;
   logic [VoltWidth:0]   volt_sum;
   logic [VoltWidth-1:0] volt_avg;
   logic [9:0]           volt_div8;
   logic [CodeWidth-1:0] level_new;
   logic [PctWidth-1:0]  pct_step;

   assign volt_get  = VoltWidth'({sample.code, 3'b000}) + MV_BASE;
   assign volt_prev = have_ff ? volt_ff : volt_get;
   assign volt_sum  = {1'b0, volt_get} + {1'b0, volt_prev};
   assign volt_avg  = volt_sum[VoltWidth:1];
   assign volt_div8 = volt_avg[VoltWidth-1:3];
   assign level_new = 8'(volt_div8 - LEVEL_BASE);

   always_comb begin
      volt_in  = volt_ff;
      have_in  = have_ff;
      level_in = level_ff;
      low_in   = low_ff;
      if (sample.taken) begin
         volt_in  = volt_avg;
         have_in  = 1'b1;
         level_in = level_new;
         if (level_new > LVL_NORMAL_ABOVE) begin
            low_in = LOW_NORMAL;
         end else if (level_new < LVL_ULTRA_BELOW) begin
            low_in = LOW_ULTRA;
         end else if (level_new < LVL_LOW_BELOW) begin
            low_in = LOW_LOW;
         end
      end
   end

   // first threshold at or below the level wins; scan backward so it lands last
   always_comb begin
      pct_step = PCT_DEFAULT;
      for (int i = StepCount - 1; i >= 0; i--) begin
         if (STEP_THRESH[i] <= level_in) begin
            pct_step = STEP_PCT[i];
         end
      end
   end

   always_comb begin
      pct_in = pct_ff;
      if (level_update) begin
         pct_in = pct_step;
         if (low_in == LOW_LOW) begin
            pct_in = PCT_LOW;
         end else if (low_in == LOW_ULTRA) begin
            pct_in = PCT_ULTRA;
         end
         if (level_in >= LVL_FULL) begin
            pct_in = PCT_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_ff  <= VOLT_RESET;
         have_ff  <= 1'b0;
         level_ff <= '0;
         low_ff   <= LOW_NORMAL;
         pct_ff   <= PCT_RESET;
      end else if (update) begin
         volt_ff  <= volt_in;
         have_ff  <= have_in;
         level_ff <= level_in;
         low_ff   <= low_in;
         pct_ff   <= pct_in;
      end
   end

   assign gauge_next.taken   = sample.taken;
   assign gauge_next.voltage = volt_in;
   assign gauge_next.low     = low_in;
   assign gauge_next.percent = pct_in;

endmodule

`default_nettype wire

// File: rtl/core/battery_gauge_from_adc_reply_core.sv
// Top level of the battery gauge fed by three-character ADC replies.
// Depends on bgauge_pkg, bgauge_decode and bgauge_state.
`default_nettype none

// Each request beat carries one ADC reply (three ASCII characters) and a
// level-mode flag; each accepted beat yields exactly one response beat with
// the sample-taken flag and the gauge state after that reply: filtered
// voltage in mV, low-battery state (0 normal, 1 low, 2 ultra low) and the
// held percentage. A beat is taken every cycle when the response side keeps
// up. The reply lands in an input register, then a single pass of decode,
// filter and hysteresis logic updates the gauge state and loads the response
// register in the same cycle, so back-to-back beats see each other's state.
// After reset the voltage reads 3699 mV, the state is normal and the
// percentage is 12 until the first sample or level update.
module battery_gauge_from_adc_reply_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [23:0] req_tdata,  // digit_hundreds[7:0], digit_tens[15:8],
                                        // digit_units[23:16]
   input  wire logic [0:0]  req_tuser,  // level_update[0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,  // voltage_mv[12:0], low_state[14:13],
                                        // level_percent[21:15], zero[23:22]
   output      logic [0:0]  rsp_tuser   // sample_taken[0]
);
   import bgauge_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [23:0] in_data_ff;
   logic        in_mode_ff;
   logic        out_valid_ff, out_valid_in;
   gauge_type   out_gauge_ff;

   logic        advance;
   sample_type  sample;
   gauge_type   gauge_next;

   // move the held reply into the response register when that slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   bgauge_decode u_decode (
      .digit_hundreds (in_data_ff[7:0]),
      .digit_tens     (in_data_ff[15:8]),
      .digit_units    (in_data_ff[23:16]),
      .sample         (sample)
   );

   // state only advances together with the reply that drives it
   bgauge_state u_state (
      .clock        (clock),
      .reset        (reset),
      .update       (advance),
      .sample       (sample),
      .level_update (in_mode_ff),
      .gauge_next   (gauge_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: load the input on acceptance and the response on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_mode_ff <= req_tuser[0];
      end
      if (advance) begin
         out_gauge_ff <= gauge_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_gauge_ff.taken;
   assign rsp_tdata  = {2'b00, out_gauge_ff.percent, out_gauge_ff.low,
                        out_gauge_ff.voltage};

   // filtered voltage never leaves the span of possible samples
   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_gauge_ff.voltage >= 13'd3352) && (out_gauge_ff.voltage <= 13'd4480))
      else $error("filtered voltage out of range");

   a_low_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:13] != 2'd3))
      else $error("undefined low state code");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_gauge_ff.percent <= PCT_FULL))
      else $error("percentage above full");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced reply lost before response");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("response overwritten while stalled");

endmodule

`default_nettype wire
